/* sv/assert_macros.svh */
// Assertion macros shared by the log ring RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on clk, disabled in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* sv/mrlr_pkg.sv */
// Types and constants for the multi-reader log ring.
package mrlr_pkg;

  localparam int LOG_DEPTH   = 1024;
  localparam int NUM_READERS = 8;
  localparam int OFF_W       = $clog2(LOG_DEPTH);
  localparam int LEN_W       = OFF_W + 1;
  localparam int SLOT_W      = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

  typedef enum logic [2:0] {
    MODE_WRITE   = 3'd0,
    MODE_CONNECT = 3'd1,
    MODE_DONE    = 3'd2,
    MODE_DISC    = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [0:0] {
    KIND_SEND = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  reader_index;
    logic [7:0]  data_byte;
    logic [9:0]  address;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  reader_id;
    logic [9:0]  start_offset;
    logic [10:0] chunk_length;
    logic [7:0]  byte_out;
    logic        is_last;
  } out_item_t;

endpackage

/* sv/multi_reader_log_ring.sv */
// busy is high until the last result is out; a new item is accepted only while busy is low.
// A write scans reader slots one per cycle through a shared offset compare/subtract unit.
// Results are strobed by out_valid for one cycle each; the receiver cannot stall.
// rst_n is synchronous, active low; the log store itself is not cleared.
`include "assert_macros.svh"

module multi_reader_log_ring
  import mrlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [7:0] log_store [LOG_DEPTH];
  logic [7:0] rd_data_r;

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [OFF_W-1:0]  wo_r, wo_nxt;
  logic [OFF_W-1:0]  oldest_r, oldest_nxt;
  logic              empty_r, empty_nxt;

  logic [OFF_W-1:0]  slot_off_r [NUM_READERS];
  logic [NUM_READERS-1:0] slot_st_r, slot_rdy_r, slot_act_r;
  logic [OFF_W-1:0]  slot_off_nxt [NUM_READERS];
  logic [NUM_READERS-1:0] slot_st_nxt, slot_rdy_nxt, slot_act_nxt;

  logic      pend_v_r, pend_v_nxt;
  out_item_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic accept;
  logic idx_ok;
  logic [SLOT_W-1:0] idx;

  // shared slot unit
  logic [OFF_W-1:0] u_off, u_src, u_next;
  logic             u_st, u_act, u_go, u_wrap, u_clr;
  logic [LEN_W-1:0] u_len;
  out_item_t        u_desc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign idx    = in_item.reader_index[SLOT_W-1:0];
  assign idx_ok = (32'(in_item.reader_index) < NUM_READERS);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (accept && in_item.mode == MODE_WRITE) begin
      log_store[wo_r] <= in_item.data_byte;
    end
    rd_data_r <= log_store[in_item.address[OFF_W-1:0]];
  end

  // slot drain unit: one slot per use
  always_comb begin
    u_off  = slot_off_r[cur_r];
    u_act  = slot_act_r[cur_r];
    u_clr  = (state_r == ST_SCAN) && u_act && slot_st_r[cur_r] && (u_off == wo_r);
    u_st   = slot_st_r[cur_r] && !u_clr;
    u_go   = ((state_r == ST_DRAIN) || u_act) && slot_rdy_r[cur_r]
             && !(u_st && u_off == wo_r) && !(!u_st && empty_r);
    u_src  = u_st ? u_off : oldest_r;
    u_wrap = (!u_st && u_src == wo_r) || (u_src > wo_r);
    u_len  = u_wrap ? (LEN_W'(LOG_DEPTH) - {1'b0, u_src})
                    : ({1'b0, wo_r} - {1'b0, u_src});
    u_next = u_wrap ? '0 : wo_r;
    u_desc = '0;
    u_desc.result_kind  = KIND_SEND;
    u_desc.reader_id    = 3'(cur_r);
    u_desc.start_offset = u_src;
    u_desc.chunk_length = u_len;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.mode)
            MODE_WRITE:   state_nxt = ST_SCAN;
            MODE_CONNECT: if (idx_ok) state_nxt = ST_DRAIN;
            MODE_DONE:    if (idx_ok && slot_act_r[idx]) state_nxt = ST_DRAIN;
            MODE_READ:    state_nxt = ST_READ;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN:  if (cur_r == SLOT_W'(NUM_READERS - 1)) state_nxt = ST_FLUSH;
      ST_DRAIN: state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_nxt       = cur_r;
    wo_nxt        = wo_r;
    oldest_nxt    = oldest_r;
    empty_nxt     = empty_r;
    slot_off_nxt  = slot_off_r;
    slot_st_nxt   = slot_st_r;
    slot_rdy_nxt  = slot_rdy_r;
    slot_act_nxt  = slot_act_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        pend_v_nxt = 1'b0;
        if (accept) begin
          case (in_item.mode)
            MODE_WRITE: begin
              cur_nxt = '0;
              if (empty_r) begin
                oldest_nxt = '0;
                empty_nxt  = 1'b0;
              end else if (oldest_r == wo_r) begin
                oldest_nxt = oldest_r + 1'b1;
              end
              if (wo_r == OFF_W'(LOG_DEPTH - 1)) begin
                wo_nxt     = '0;
                oldest_nxt = '0;
              end else begin
                wo_nxt = wo_r + 1'b1;
              end
            end
            MODE_CONNECT: begin
              if (idx_ok) begin
                cur_nxt           = idx;
                slot_act_nxt[idx] = 1'b1;
                slot_st_nxt[idx]  = 1'b0;
                slot_rdy_nxt[idx] = 1'b1;
                slot_off_nxt[idx] = '0;
              end
            end
            MODE_DONE: begin
              if (idx_ok && slot_act_r[idx]) begin
                cur_nxt           = idx;
                slot_rdy_nxt[idx] = 1'b1;
              end
            end
            MODE_DISC: begin
              if (idx_ok) begin
                slot_act_nxt[idx] = 1'b0;
                slot_st_nxt[idx]  = 1'b0;
                slot_rdy_nxt[idx] = 1'b0;
                slot_off_nxt[idx] = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN, ST_DRAIN: begin
        if (state_r == ST_SCAN) begin
          cur_nxt = cur_r + 1'b1;
        end
        if (u_clr) begin
          slot_st_nxt[cur_r] = 1'b0;
        end
        if (u_go) begin
          slot_off_nxt[cur_r] = u_next;
          slot_st_nxt[cur_r]  = 1'b1;
          slot_rdy_nxt[cur_r] = 1'b0;
          // hold one descriptor back so the last one can be flagged
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = pend_r;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = u_desc;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt         = pend_r;
          out_item_nxt.is_last = 1'b1;
        end
        pend_v_nxt = 1'b0;
      end
      ST_READ: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt              = '0;
        out_item_nxt.result_kind  = KIND_READ;
        out_item_nxt.byte_out     = rd_data_r;
        out_item_nxt.is_last      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      wo_r        <= '0;
      oldest_r    <= '0;
      empty_r     <= 1'b1;
      slot_off_r  <= '{default: '0};
      slot_st_r   <= '0;
      slot_rdy_r  <= '0;
      slot_act_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      wo_r        <= wo_nxt;
      oldest_r    <= oldest_nxt;
      empty_r     <= empty_nxt;
      slot_off_r  <= slot_off_nxt;
      slot_st_r   <= slot_st_nxt;
      slot_rdy_r  <= slot_rdy_nxt;
      slot_act_r  <= slot_act_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  `ASSERT_NOW(a_last_then_idle, out_valid && out_item.is_last, !busy)
  `ASSERT_NEXT(a_no_result_after_accept, accept, !out_valid)
  `ASSERT_NEXT(a_write_advances, accept && in_item.mode == MODE_WRITE,
               wo_r == (($past(wo_r) == OFF_W'(LOG_DEPTH - 1)) ? '0 : $past(wo_r) + 1'b1))
  `ASSERT_NEXT(a_flush_ends_item, state_r == ST_FLUSH, !busy && !pend_v_r)

endmodule
